// File: rtl/core/cke_pkg.sv
// ----------------------------------------------------------------------------
// cke_pkg
// Shared types, character codes, elaboration-time helpers and the key
// reduction function of the column keyed text encoder.
// ----------------------------------------------------------------------------
package cke_pkg;

   localparam int NUM_BASE = 1000000;
   localparam int BASE_W   = 20;

   localparam int          MUL_W       = 32;
   localparam logic [31:0] RECIP_MUL   = 32'hCCCCCCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_1 = 8'h31;
   localparam logic [7:0] CH_DIGIT_2 = 8'h32;
   localparam logic [7:0] CH_DIGIT_3 = 8'h33;
   localparam logic [7:0] CH_DIGIT_4 = 8'h34;
   localparam logic [7:0] CH_DIGIT_5 = 8'h35;
   localparam logic [7:0] CH_DIGIT_6 = 8'h36;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam logic [4:0] ALPHA_LEN = 5'd26;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last_out;
      logic       message_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] column_key;
   } csr_payload_type;

   typedef struct packed {
      logic [7:0] mapped;
      logic       is_digit;
      logic [3:0] digit;
      logic [4:0] next_shift;
   } char_info_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONV,
      ST_HASH_A,
      ST_LEN_TENS,
      ST_LEN_ONES,
      ST_HASH_B,
      ST_SIGN,
      ST_DIGIT,
      ST_HASH_C,
      ST_CHAR
   } top_state_type;

   typedef enum logic [1:0] {
      DGT_IDLE,
      DGT_MUL,
      DGT_SUB
   } dgt_state_type;

   function automatic int pow10(input int n);
      int v;
      v = 1;
      for (int i = 0; i < n; i++) begin
         v = v * 10;
      end
      return v;
   endfunction

   function automatic int dec_digits(input int x);
      int n;
      int v;
      n = 1;
      v = x / 10;
      while (v != 0) begin
         n = n + 1;
         v = v / 10;
      end
      return n;
   endfunction

   // k mod 26 for an 8-bit k through a reciprocal estimate
   function automatic logic [4:0] key_mod26(input logic [7:0] k);
      logic [14:0] prod;
      logic [3:0]  quo;
      logic [7:0]  rem;
      prod = 15'(k) * 15'd79;
      quo  = prod[14:11];
      rem  = k - 8'((quo << 4) + (quo << 3) + (quo << 1));
      if (rem >= 8'(ALPHA_LEN)) begin
         rem = rem - 8'(ALPHA_LEN);
      end
      return rem[4:0];
   endfunction

endpackage

// File: rtl/core/cke_stream_if.sv
// ----------------------------------------------------------------------------
// cke_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface cke_stream_if #(parameter type payload_type = logic [7:0]);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// File: rtl/core/cke_char_map.sv
// ----------------------------------------------------------------------------
// cke_char_map
// Per-byte mapping: letter rotation, punctuation to digit, digit detection
// and the letter shift for the following byte.
// ----------------------------------------------------------------------------
module cke_char_map
   import cke_pkg::*;
(
   input  logic [7:0]    char_in,
   input  logic [4:0]    shift,
   input  logic [4:0]    key_mod,
   output char_info_type info
);

   logic       is_upper;
   logic       is_lower;
   logic [7:0] base_char;
   logic [4:0] rot_off;
   logic [5:0] rot_sum;
   logic [4:0] rot_mod;
   logic [5:0] adv_sum;
   logic [4:0] adv_mod;

   always_comb begin
      is_upper  = char_in inside {[CH_UPPER_A:CH_UPPER_Z]};
      is_lower  = char_in inside {[CH_LOWER_A:CH_LOWER_Z]};
      base_char = is_upper ? CH_UPPER_A : CH_LOWER_A;
      rot_off   = 5'(char_in - base_char);
      rot_sum   = {1'b0, rot_off} + {1'b0, shift};
      rot_mod   = (rot_sum >= 6'(ALPHA_LEN)) ? 5'(rot_sum - 6'(ALPHA_LEN)) : rot_sum[4:0];
      adv_sum   = {1'b0, shift} + {1'b0, key_mod};
      adv_mod   = (adv_sum >= 6'(ALPHA_LEN)) ? 5'(adv_sum - 6'(ALPHA_LEN)) : adv_sum[4:0];

      info.mapped     = char_in;
      info.is_digit   = char_in inside {[CH_DIGIT_0:CH_DIGIT_9]};
      info.digit      = char_in[3:0];
      info.next_shift = shift;

      if (is_upper || is_lower) begin
         info.mapped     = base_char + {3'b000, rot_mod};
         info.next_shift = adv_mod;
      end else if (char_in == CH_SLASH) begin
         info.next_shift = key_mod;
      end else begin
         case (char_in)
            CH_BANG:    info.mapped = CH_DIGIT_1;
            CH_QUEST:   info.mapped = CH_DIGIT_2;
            CH_COMMA:   info.mapped = CH_DIGIT_3;
            CH_SEMI:    info.mapped = CH_DIGIT_4;
            CH_COLON:   info.mapped = CH_DIGIT_5;
            CH_PERCENT: info.mapped = CH_DIGIT_6;
            default:    info.mapped = char_in;
         endcase
      end
   end

endmodule

// File: rtl/core/cke_digit_unit.sv
// ----------------------------------------------------------------------------
// cke_digit_unit
// Splits a magnitude into decimal digits, least significant first, with one
// shared reciprocal multiplier: multiply in DGT_MUL, remainder in the DGT_SUB that follows.
// ----------------------------------------------------------------------------
module cke_digit_unit
   import cke_pkg::*;
#(
   parameter int MAG_W     = 30,
   parameter int DIG_DEPTH = 9,
   parameter int CNT_W     = 4,
   parameter int IDX_W     = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] mag,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [3:0]       rd_digit,
   output logic [CNT_W-1:0] count,
   output logic             done
);

   dgt_state_type        state_ff, state_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 done_ff, done_in;
   logic [3:0]           digits_ff [DIG_DEPTH];
   logic                 wr_en;
   logic [2*MUL_W-1:0]   prod;
   logic [MAG_W-1:0]     diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DGT_IDLE;
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (wr_en) begin
         digits_ff[count_ff[IDX_W-1:0]] <= diff[3:0];
      end
   end

   always_comb begin
      prod     = (2*MUL_W)'(rem_ff) * (2*MUL_W)'(RECIP_MUL);
      diff     = rem_ff - MAG_W'((quo_ff << 3) + (quo_ff << 1));
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      done_in  = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         DGT_IDLE: begin
            if (start) begin
               rem_in   = mag;
               count_in = '0;
               state_in = DGT_MUL;
            end
         end
         DGT_MUL: begin
            quo_in   = MAG_W'(prod >> RECIP_SHIFT);
            state_in = DGT_SUB;
         end
         DGT_SUB: begin
            wr_en    = 1'b1;
            count_in = count_ff + 1'b1;
            rem_in   = quo_ff;
            if (quo_ff == '0) begin
               done_in  = 1'b1;
               state_in = DGT_IDLE;
            end else begin
               state_in = DGT_MUL;
            end
         end
         default: state_in = DGT_IDLE;
      endcase
   end

   assign rd_digit = digits_ff[rd_idx];
   assign count    = count_ff;
   assign done     = done_ff;

endmodule

// File: rtl/core/column_keyed_text_encoder.sv
// ----------------------------------------------------------------------------
// column_keyed_text_encoder
// Keyed letter rotation with digit-run replacement by an encoded difference
// from one million.
// ----------------------------------------------------------------------------
//  channel   dir   payload                               handshake
//  req_chan  in    char_in, end_of_message               valid/ready
//  rsp_chan  out   char_out, last_out, message_done      valid/ready, registered
//  csr_chan  in    column_key                            valid/ready, always ready
//
//  a digit request without end_of_message is taken in ST_IDLE; a non-digit
//  request with no run pending is emitted from ST_CHAR
//  a request that flushes a run starts the shared reciprocal divider in ST_CONV,
//  which yields one decimal digit per DGT_MUL/DGT_SUB pair, then one byte per cycle
//  unless response stalls hold the emitter; reset is synchronous and needs no sweep
// ----------------------------------------------------------------------------
module column_keyed_text_encoder
   import cke_pkg::*;
#(
   parameter int MAX_RUN_DIGITS = 7
) (
   input logic          clock,
   input logic          reset,
   cke_stream_if.sink   req_chan,
   cke_stream_if.source rsp_chan,
   cke_stream_if.sink   csr_chan
);

   localparam int RUN_LIMIT = pow10(MAX_RUN_DIGITS) - 1;
   localparam int VAL_W     = $clog2(RUN_LIMIT + 1);
   localparam int MAG_W     = (VAL_W > BASE_W) ? VAL_W : BASE_W;
   localparam int MAG_MAX   = (RUN_LIMIT > NUM_BASE) ? (RUN_LIMIT - NUM_BASE) : NUM_BASE;
   localparam int DIG_DEPTH = dec_digits(MAG_MAX);
   localparam int CNT_W     = $clog2(DIG_DEPTH + 1);
   localparam int IDX_W     = $clog2(DIG_DEPTH);
   localparam int LEN_W     = CNT_W + 1;

   top_state_type    state_ff, state_in;
   logic [4:0]       key_mod_ff, key_mod_in;
   logic [4:0]       shift_ff, shift_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic             active_ff, active_in;
   logic [7:0]       char_ff, char_in;
   logic             eom_ff, eom_in;
   logic             pending_ff, pending_in;
   logic             neg_ff, neg_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   req_payload_type  req_data;
   char_info_type    info;
   logic             accept;
   logic [VAL_W+3:0] value_x10;
   logic [VAL_W-1:0] value_sat;
   logic [VAL_W-1:0] run_value;
   logic [MAG_W-1:0] run_ext;
   logic             run_neg;
   logic [MAG_W-1:0] run_mag;
   logic             conv_start;
   logic [3:0]       rd_digit;
   logic [CNT_W-1:0] dig_count;
   logic             conv_done;
   logic [LEN_W-1:0] msg_len;
   logic             len_wide;
   logic [LEN_W-1:0] len_ones;
   logic             out_free;
   logic             emit;
   logic [7:0]       emit_char;
   logic             emit_last;

   cke_char_map u_char_map (
      .char_in (req_data.char_in),
      .shift   (shift_ff),
      .key_mod (key_mod_ff),
      .info    (info)
   );

   cke_digit_unit #(
      .MAG_W     (MAG_W),
      .DIG_DEPTH (DIG_DEPTH),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
   ) u_digit_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (conv_start),
      .mag      (run_mag),
      .rd_idx   (idx_ff),
      .rd_digit (rd_digit),
      .count    (dig_count),
      .done     (conv_done)
   );

   assign req_data         = req_chan.payload;
   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         key_mod_ff   <= '0;
         shift_ff     <= '0;
         value_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_mod_ff   <= key_mod_in;
         shift_ff     <= shift_in;
         value_ff     <= value_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff        <= char_in;
      eom_ff         <= eom_in;
      pending_ff     <= pending_in;
      neg_ff         <= neg_in;
      idx_ff         <= idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // run value and message length arithmetic
   always_comb begin
      value_x10 = (VAL_W+4)'({value_ff, 3'b000}) + (VAL_W+4)'({value_ff, 1'b0})
                + (VAL_W+4)'(info.digit);
      value_sat = (value_x10 > (VAL_W+4)'(RUN_LIMIT)) ? VAL_W'(RUN_LIMIT)
                                                      : value_x10[VAL_W-1:0];
      run_value = info.is_digit ? value_sat : value_ff;
      run_ext   = MAG_W'(run_value);
      run_neg   = run_ext > MAG_W'(NUM_BASE);
      run_mag   = run_neg ? (run_ext - MAG_W'(NUM_BASE)) : (MAG_W'(NUM_BASE) - run_ext);
      msg_len   = LEN_W'(dig_count) + LEN_W'(neg_ff);
      len_wide  = msg_len >= LEN_W'(10);
      len_ones  = len_wide ? (msg_len - LEN_W'(10)) : msg_len;
   end

   always_comb begin
      accept     = req_chan.valid && req_chan.ready;
      out_free   = !rsp_valid_ff || rsp_chan.ready;
      state_in   = state_ff;
      key_mod_in = key_mod_ff;
      shift_in   = shift_ff;
      value_in   = value_ff;
      active_in  = active_ff;
      char_in    = char_ff;
      eom_in     = eom_ff;
      pending_in = pending_ff;
      neg_in     = neg_ff;
      idx_in     = idx_ff;
      conv_start = 1'b0;
      emit       = 1'b0;
      emit_char  = CH_HASH;
      emit_last  = 1'b0;

      if (csr_chan.valid) begin
         key_mod_in = key_mod26(csr_chan.payload.column_key);
         shift_in   = key_mod26(csr_chan.payload.column_key);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eom_in = req_data.end_of_message;
               char_in = info.mapped;
               neg_in  = run_neg;
               if (info.is_digit) begin
                  value_in   = value_sat;
                  active_in  = 1'b1;
                  pending_in = 1'b0;
                  if (req_data.end_of_message) begin
                     conv_start = 1'b1;
                     value_in   = '0;
                     active_in  = 1'b0;
                     shift_in   = key_mod_ff;
                     state_in   = ST_CONV;
                  end
               end else begin
                  pending_in = 1'b1;
                  shift_in   = req_data.end_of_message ? key_mod_ff : info.next_shift;
                  if (active_ff) begin
                     conv_start = 1'b1;
                     value_in   = '0;
                     active_in  = 1'b0;
                     state_in   = ST_CONV;
                  end else begin
                     state_in = ST_CHAR;
                  end
               end
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_HASH_A;
            end
         end
         ST_HASH_A: begin
            emit = 1'b1;
            if (out_free) begin
               state_in = len_wide ? ST_LEN_TENS : ST_LEN_ONES;
            end
         end
         ST_LEN_TENS: begin
            emit      = 1'b1;
            emit_char = CH_DIGIT_1;
            if (out_free) begin
               state_in = ST_LEN_ONES;
            end
         end
         ST_LEN_ONES: begin
            emit      = 1'b1;
            emit_char = CH_DIGIT_0 + 8'(len_ones);
            if (out_free) begin
               state_in = ST_HASH_B;
            end
         end
         ST_HASH_B: begin
            emit = 1'b1;
            if (out_free) begin
               idx_in   = IDX_W'(dig_count - 1'b1);
               state_in = neg_ff ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            emit      = 1'b1;
            emit_char = CH_MINUS;
            if (out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            emit      = 1'b1;
            emit_char = CH_DIGIT_0 + 8'(rd_digit);
            if (out_free) begin
               if (idx_ff == '0) begin
                  state_in = ST_HASH_C;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_HASH_C: begin
            emit      = 1'b1;
            emit_last = !pending_ff;
            if (out_free) begin
               state_in = pending_ff ? ST_CHAR : ST_IDLE;
            end
         end
         ST_CHAR: begin
            emit      = 1'b1;
            emit_char = char_ff;
            emit_last = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_payload_in = rsp_payload_ff;
      if (emit && out_free) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.char_out     = emit_char;
         rsp_payload_in.last_out     = emit_last;
         rsp_payload_in.message_done = emit_last && eom_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

endmodule
